### rtl/core/fcs_pkg.sv
// Shared types and constants for the frame cadence scheduler.
`timescale 1ns / 1ps
`default_nettype none

package fcs_pkg;

    localparam int FRAME_BITS   = 32;
    localparam int GEN_BITS     = 32;
    localparam int GAP_BITS     = 18;
    localparam int IVL_BITS     = 3;
    localparam int OUT_CNT_BITS = 32;
    localparam int OP_BITS      = 3;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [IVL_BITS-1:0] IVL_RESET = 3'd2;
    localparam logic [GAP_BITS-1:0] GAP_RESET = 18'd200000;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_INTERVAL = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_GAP        = 1'd1;

    typedef enum logic [OP_BITS-1:0] {
        OP_OFFER      = 3'd0,
        OP_ADMIT      = 3'd1,
        OP_FINISH     = 3'd2,
        OP_CANCEL     = 3'd3,
        OP_CANCEL_GEN = 3'd4
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FRAME,
        S_TIME,
        S_LAST,
        S_GAP,
        S_IVL,
        S_DIV,
        S_EXP,
        S_COMMIT
    } t_state;

    typedef enum logic [2:0] {
        ALU_NONE,
        ALU_FRAME,
        ALU_TIME,
        ALU_LAST,
        ALU_GAP,
        ALU_IVL,
        ALU_DIV,
        ALU_EXP
    } t_alu_sel;

    typedef struct packed {
        logic borrow;
        logic zero;
    } t_alu_flags;

endpackage

`default_nettype wire

### rtl/core/fcs_alu.sv
// Shared subtract/compare unit with operand selection for the scheduler sequencer.
`timescale 1ns / 1ps
`default_nettype none

module fcs_alu #(
    parameter int TIME_BITS = 48
) (
    input  fcs_pkg::t_alu_sel                  i_sel,
    input  wire logic [fcs_pkg::FRAME_BITS-1:0] i_frame,
    input  wire logic [fcs_pkg::FRAME_BITS-1:0] i_prev_frame,
    input  wire logic [TIME_BITS-1:0]           i_time,
    input  wire logic [TIME_BITS-1:0]           i_prev_time,
    input  wire logic [TIME_BITS-1:0]           i_last_time,
    input  wire logic [TIME_BITS-1:0]           i_work,
    input  wire logic [fcs_pkg::GAP_BITS-1:0]   i_gap,
    input  wire logic [fcs_pkg::GAP_BITS-1:0]   i_rem,
    input  wire logic [31:0]                    i_frames,
    input  wire logic [31:0]                    i_frame_idx,
    input  wire logic [31:0]                    i_expired,
    input  wire logic [31:0]                    i_reported,
    output logic [TIME_BITS-1:0]                o_diff,
    output fcs_pkg::t_alu_flags                 o_flags
);
    import fcs_pkg::*;

    logic [TIME_BITS-1:0] opa;
    logic [TIME_BITS-1:0] opb;
    logic [TIME_BITS:0]   sub;

    always_comb begin
        opa = '0;
        opb = '0;
        case (i_sel)
            ALU_FRAME: begin
                opa = TIME_BITS'(i_prev_frame);
                opb = TIME_BITS'(i_frame);
            end
            ALU_TIME: begin
                opa = i_time;
                opb = i_prev_time;
            end
            ALU_LAST: begin
                opa = i_time;
                opb = i_last_time;
            end
            ALU_GAP: begin
                opa = i_work;
                opb = TIME_BITS'(i_gap);
            end
            ALU_IVL: begin
                opa = TIME_BITS'(i_frames);
                opb = TIME_BITS'(i_frame_idx);
            end
            ALU_DIV: begin
                opa = TIME_BITS'({i_rem, i_work[TIME_BITS-1]});
                opb = TIME_BITS'(i_gap);
            end
            ALU_EXP: begin
                opa = TIME_BITS'(i_expired);
                opb = TIME_BITS'(i_reported);
            end
            default: begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    assign sub     = {1'b0, opa} - {1'b0, opb};
    assign o_diff  = sub[TIME_BITS-1:0];
    assign o_flags = '{borrow: sub[TIME_BITS], zero: (opa == opb)};

endmodule

`default_nettype wire

### rtl/core/frame_cadence_scheduler.sv
// Top level of the frame cadence scheduler: event sequencer, state and counters.
`timescale 1ns / 1ps
`default_nettype none

// One event is taken at a time; o_in_stall stays high until its result is
// registered. Finish, cancel and unknown events go from accept straight to the
// commit state. Offer and admit first run five compare steps on the single
// shared subtractor. An offer that finds the gap deadline passed while a job
// is busy also runs a restoring division of the elapsed time by the gap, one
// quotient bit per cycle on that same subtractor, and then an expiry compare.
// A result waiting on a stalled output does not hold off the next event, only
// its final write-back.
module frame_cadence_scheduler #(
    parameter int TIME_BITS  = 48,
    parameter int COUNT_BITS = 32
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [fcs_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  wire logic [fcs_pkg::GAP_BITS-1:0]         i_cfg_data,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic [fcs_pkg::OP_BITS-1:0]          i_operation,
    input  wire logic [fcs_pkg::FRAME_BITS-1:0]       i_frame_number,
    input  wire logic [TIME_BITS-1:0]                 i_capture_time_us,
    input  wire logic                                 i_external_trigger,
    input  wire logic [fcs_pkg::GEN_BITS-1:0]         i_job_generation,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic                                      o_accepted,
    output logic                                      o_detector_busy,
    output logic [fcs_pkg::OUT_CNT_BITS-1:0]          o_missed_deadlines,
    output logic [fcs_pkg::OUT_CNT_BITS-1:0]          o_capture_count
);
    import fcs_pkg::*;

    localparam int CNT_W = $clog2(TIME_BITS);
    localparam int SUM_W = ((COUNT_BITS > 32) ? COUNT_BITS : 32) + 1;

    // configuration
    logic [IVL_BITS-1:0] r_interval;
    logic [GAP_BITS-1:0] r_max_gap;
    logic [GAP_BITS-1:0] gap_eff;

    // sequencer
    t_state r_state, n_state;
    t_alu_sel alu_sel;
    logic [TIME_BITS-1:0] alu_diff;
    t_alu_flags alu_flags;
    logic out_free;
    logic commit_go;
    logic in_fire;

    // latched event
    logic [OP_BITS-1:0]    r_op;
    logic [FRAME_BITS-1:0] r_frame;
    logic [TIME_BITS-1:0]  r_time;
    logic                  r_trig;
    logic [GEN_BITS-1:0]   r_gen;

    // evaluation results
    logic                  r_frame_le, r_frame_eq, r_time_lt, r_time_eq, r_last_ge;
    logic                  r_gap_ok, r_ivl_ok, r_exp_gt;
    logic [TIME_BITS-1:0]  r_work;
    logic [GAP_BITS-1:0]   r_rem;
    logic [CNT_W-1:0]      r_cnt;
    logic [31:0]           r_frames_eval;
    logic [31:0]           r_expired;
    logic [31:0]           r_delta;
    logic                  div_bit;
    logic [63:0]           quot_wide;
    logic [31:0]           expired_sat;

    // scheduler state
    logic                  r_have_frame, n_have_frame;
    logic [FRAME_BITS-1:0] r_prev_frame, n_prev_frame;
    logic [TIME_BITS-1:0]  r_prev_time, n_prev_time;
    logic [31:0]           r_frames_seen, n_frames_seen;
    logic                  r_req, n_req;
    logic                  r_have_att, n_have_att;
    logic [TIME_BITS-1:0]  r_last_time, n_last_time;
    logic [31:0]           r_frame_idx, n_frame_idx;
    logic                  r_busy, n_busy;
    logic [FRAME_BITS-1:0] r_run_frame, n_run_frame;
    logic [GEN_BITS-1:0]   r_run_gen, n_run_gen;
    logic [31:0]           r_reported, n_reported;
    logic [COUNT_BITS-1:0] r_misses, n_misses;
    logic [COUNT_BITS-1:0] r_admitted, n_admitted;
    logic                  n_acc;

    logic                  refuse;
    logic                  early;
    logic                  fin_match;
    logic [SUM_W-1:0]      miss_sum;
    logic [63:0]           misses_wide;
    logic [63:0]           admitted_wide;

    // output register
    logic                    r_out_valid;
    logic                    r_out_acc;
    logic                    r_out_busy;
    logic [OUT_CNT_BITS-1:0] r_out_misses;
    logic [OUT_CNT_BITS-1:0] r_out_captures;

    function automatic logic op_is_eval(input logic [OP_BITS-1:0] op);
        op_is_eval = (op == OP_OFFER) || (op == OP_ADMIT);
    endfunction

    assign gap_eff   = (r_max_gap == '0) ? GAP_BITS'(1) : r_max_gap;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign in_fire   = i_in_valid && !o_in_stall;

    fcs_alu #(
        .TIME_BITS (TIME_BITS)
    ) u_alu (
        .i_sel        (alu_sel),
        .i_frame      (r_frame),
        .i_prev_frame (r_prev_frame),
        .i_time       (r_time),
        .i_prev_time  (r_prev_time),
        .i_last_time  (r_last_time),
        .i_work       (r_work),
        .i_gap        (gap_eff),
        .i_rem        (r_rem),
        .i_frames     (r_frames_eval),
        .i_frame_idx  (r_frame_idx),
        .i_expired    (expired_sat),
        .i_reported   (r_reported),
        .o_diff       (alu_diff),
        .o_flags      (alu_flags)
    );

    assign div_bit     = !alu_flags.borrow;
    assign quot_wide   = 64'(r_work);
    assign expired_sat = (|quot_wide[63:32]) ? 32'hFFFF_FFFF : quot_wide[31:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (op_is_eval(i_operation)) n_state = S_FRAME;
                    else n_state = S_COMMIT;
                end
            end
            S_FRAME: n_state = S_TIME;
            S_TIME:  n_state = S_LAST;
            S_LAST:  n_state = S_GAP;
            S_GAP:   n_state = S_IVL;
            S_IVL: begin
                if (r_op == OP_OFFER && !refuse && r_gap_ok && r_busy) n_state = S_DIV;
                else n_state = S_COMMIT;
            end
            S_DIV: begin
                if (r_cnt == '0) n_state = S_EXP;
            end
            S_EXP: n_state = S_COMMIT;
            S_COMMIT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        alu_sel    = ALU_NONE;
        o_in_stall = 1'b1;
        commit_go  = 1'b0;
        case (r_state)
            S_IDLE:   o_in_stall = 1'b0;
            S_FRAME:  alu_sel = ALU_FRAME;
            S_TIME:   alu_sel = ALU_TIME;
            S_LAST:   alu_sel = ALU_LAST;
            S_GAP:    alu_sel = ALU_GAP;
            S_IVL:    alu_sel = ALU_IVL;
            S_DIV:    alu_sel = ALU_DIV;
            S_EXP:    alu_sel = ALU_EXP;
            S_COMMIT: commit_go = out_free;
            default:  alu_sel = ALU_NONE;
        endcase
    end

    assign refuse    = r_have_frame && (r_frame_le || r_time_lt);
    assign early     = !r_req && !r_ivl_ok && !r_gap_ok && r_have_att;
    assign fin_match = r_busy && (r_run_frame == r_frame) && (r_run_gen == r_gen);
    assign miss_sum  = SUM_W'(r_misses) + SUM_W'(r_delta);

    // event commit
    always_comb begin
        n_have_frame  = r_have_frame;
        n_prev_frame  = r_prev_frame;
        n_prev_time   = r_prev_time;
        n_frames_seen = r_frames_seen;
        n_req         = r_req;
        n_have_att    = r_have_att;
        n_last_time   = r_last_time;
        n_frame_idx   = r_frame_idx;
        n_busy        = r_busy;
        n_run_frame   = r_run_frame;
        n_run_gen     = r_run_gen;
        n_reported    = r_reported;
        n_misses      = r_misses;
        n_admitted    = r_admitted;
        n_acc         = 1'b0;
        case (t_op'(r_op))
            OP_OFFER: begin
                if (!refuse) begin
                    n_have_frame  = 1'b1;
                    n_prev_frame  = r_frame;
                    n_prev_time   = r_time;
                    n_frames_seen = r_frames_eval;
                    if (r_trig) n_req = 1'b1;
                    if (r_exp_gt) begin
                        if (|miss_sum[SUM_W-1:COUNT_BITS]) n_misses = '1;
                        else n_misses = miss_sum[COUNT_BITS-1:0];
                        n_reported = r_expired;
                    end
                    n_acc = n_req || r_ivl_ok || r_gap_ok;
                end
            end
            OP_ADMIT: begin
                if (!r_busy && r_gen != '0 && r_have_frame && r_frame_eq && r_time_eq
                        && !early) begin
                    n_busy      = 1'b1;
                    n_run_frame = r_frame;
                    n_run_gen   = r_gen;
                    n_have_att  = 1'b1;
                    n_last_time = r_time;
                    n_frame_idx = r_frames_seen;
                    n_req       = 1'b0;
                    n_reported  = '0;
                    if (!(&r_admitted)) n_admitted = r_admitted + COUNT_BITS'(1);
                    n_acc       = 1'b1;
                end
            end
            OP_FINISH, OP_CANCEL: begin
                if (fin_match) begin
                    n_busy      = 1'b0;
                    n_run_frame = '0;
                    n_run_gen   = '0;
                    n_acc       = 1'b1;
                    if (r_op == OP_CANCEL) n_req = 1'b1;
                end
            end
            OP_CANCEL_GEN: begin
                if (r_busy && r_run_gen == r_gen) begin
                    n_busy      = 1'b0;
                    n_run_frame = '0;
                    n_run_gen   = '0;
                end
                n_req       = 1'b1;
                n_have_att  = 1'b0;
                n_last_time = '0;
                n_reported  = '0;
                n_acc       = 1'b1;
            end
            default: n_acc = 1'b0;
        endcase
    end

    assign misses_wide   = 64'(n_misses);
    assign admitted_wide = 64'(n_admitted);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= IVL_RESET;
            r_max_gap  <= GAP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_INTERVAL: r_interval <= i_cfg_data[IVL_BITS-1:0];
                CFG_MAX_GAP:        r_max_gap  <= i_cfg_data;
                default:            r_interval <= r_interval;
            endcase
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    // event latch and evaluation datapath
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op    <= i_operation;
            r_frame <= i_frame_number;
            r_time  <= i_capture_time_us;
            r_trig  <= i_external_trigger;
            r_gen   <= i_job_generation;
        end
        case (r_state)
            S_FRAME: begin
                r_frame_le    <= !alu_flags.borrow;
                r_frame_eq    <= alu_flags.zero;
                r_frames_eval <= (r_op == OP_OFFER) ? r_frames_seen + 32'd1 : r_frames_seen;
            end
            S_TIME: begin
                r_time_lt <= alu_flags.borrow;
                r_time_eq <= alu_flags.zero;
            end
            S_LAST: begin
                r_last_ge <= !alu_flags.borrow;
                r_work    <= alu_diff;
            end
            S_GAP: r_gap_ok <= r_have_att && r_last_ge && !alu_flags.borrow;
            S_IVL: begin
                r_ivl_ok <= r_have_att
                    && ((|alu_diff[31:IVL_BITS]) || (alu_diff[IVL_BITS-1:0] >= r_interval));
                r_exp_gt <= 1'b0;
                r_rem    <= '0;
                r_cnt    <= CNT_W'(TIME_BITS - 1);
            end
            S_DIV: begin
                if (div_bit) r_rem <= alu_diff[GAP_BITS-1:0];
                else r_rem <= {r_rem[GAP_BITS-2:0], r_work[TIME_BITS-1]};
                r_work <= {r_work[TIME_BITS-2:0], div_bit};
                r_cnt  <= r_cnt - CNT_W'(1);
            end
            S_EXP: begin
                r_exp_gt  <= !alu_flags.borrow && !alu_flags.zero;
                r_delta   <= alu_diff[31:0];
                r_expired <= expired_sat;
            end
            default: r_cnt <= r_cnt;
        endcase
    end

    // scheduler state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_frame  <= 1'b0;
            r_prev_frame  <= '0;
            r_prev_time   <= '0;
            r_frames_seen <= '0;
            r_req         <= 1'b1;
            r_have_att    <= 1'b0;
            r_last_time   <= '0;
            r_frame_idx   <= '0;
            r_busy        <= 1'b0;
            r_run_frame   <= '0;
            r_run_gen     <= '0;
            r_reported    <= '0;
            r_misses      <= '0;
            r_admitted    <= '0;
        end else if (commit_go) begin
            r_have_frame  <= n_have_frame;
            r_prev_frame  <= n_prev_frame;
            r_prev_time   <= n_prev_time;
            r_frames_seen <= n_frames_seen;
            r_req         <= n_req;
            r_have_att    <= n_have_att;
            r_last_time   <= n_last_time;
            r_frame_idx   <= n_frame_idx;
            r_busy        <= n_busy;
            r_run_frame   <= n_run_frame;
            r_run_gen     <= n_run_gen;
            r_reported    <= n_reported;
            r_misses      <= n_misses;
            r_admitted    <= n_admitted;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit_go) begin
            r_out_acc      <= n_acc;
            r_out_busy     <= n_busy;
            r_out_misses   <= misses_wide[OUT_CNT_BITS-1:0];
            r_out_captures <= admitted_wide[OUT_CNT_BITS-1:0];
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_accepted         = r_out_acc;
    assign o_detector_busy    = r_out_busy;
    assign o_missed_deadlines = r_out_misses;
    assign o_capture_count    = r_out_captures;

    a_busy_has_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_run_gen != '0))
        else $error("busy job without a generation tag");

    a_commit_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit_go |=> (r_out_valid && r_state == S_IDLE))
        else $error("commit did not present a result");

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == '0) |=> (r_state == S_EXP))
        else $error("division did not end after its last quotient bit");

    a_captures_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_admitted != '0) |=> (r_admitted != '0))
        else $error("capture count dropped back to zero");

endmodule

`default_nettype wire
